### hw/rtl/rc4s_pkg.sv
// rc4s_pkg: shared sizes, payload structs, datapath op codes and control/status
// structs for the 9-bit rc4-style stream decryptor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rc4s_pkg;

  localparam int unsigned TABLE_SIZE = 512;
  localparam int unsigned KEY_MAX    = 16;
  localparam int unsigned SYM_W      = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_MAX);
  localparam int unsigned KLEN_W     = 5;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KIDX_W     = 4;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = KLEN_W'(9);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_KEY = 2'd0,
    FUNC_SCHEDULE = 2'd1,
    FUNC_DECRYPT  = 2'd2,
    FUNC_NOP      = 2'd3
  } func_e;

  // register word index within the configuration space
  typedef enum logic {
    REG_KEY_LENGTH = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KIDX_W-1:0] key_index;
    logic [SYM_W-1:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] plain_symbol;
    logic             data_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FILL,
    OP_K_RD_I,
    OP_K_RD_J,
    OP_K_WR_I,
    OP_K_WR_J,
    OP_K_END,
    OP_D_RD_I,
    OP_D_RD_J,
    OP_D_WR_I,
    OP_D_WR_J,
    OP_D_RD_K,
    OP_D_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
    logic   out_data;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
    logic same_idx;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/rc4s_dpath.sv
// rc4s_dpath: permutation memory, key store, counters and output payload register.
// Depends on rc4s_pkg; driven by rc4s_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_dpath (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  rc4s_pkg::dp_cmd_t           cmd_i,
  input  rc4s_pkg::in_item_t          in_data_i,
  input  wire [rc4s_pkg::KLEN_W-1:0]  key_length_i,
  output rc4s_pkg::dp_status_t        status_o,
  output rc4s_pkg::out_item_t         out_data_o
);

  localparam int unsigned SW = rc4s_pkg::SYM_W;
  localparam int unsigned KW = rc4s_pkg::KEY_IDX_W;

  logic [SW-1:0] perm_mem [rc4s_pkg::TABLE_SIZE];
  logic [SW-1:0] key_store [rc4s_pkg::KEY_MAX];

  logic [SW-1:0] rdata_q;
  logic [SW-1:0] n_q, n_d;
  logic [KW-1:0] kctr_q, kctr_d;
  logic [SW-1:0] i_q, i_d;
  logic [SW-1:0] j_q, j_d;
  logic [SW-1:0] prev_q, prev_d;
  logic [SW-1:0] sym_q;
  logic [SW-1:0] key_q;
  logic [SW-1:0] x_q;
  logic [SW-1:0] sum_q;
  logic          same_q;
  logic [SW-1:0] res_q;
  rc4s_pkg::out_item_t out_q;

  logic          mem_we;
  logic [SW-1:0] mem_addr;
  logic [SW-1:0] mem_wdata;
  logic [SW-1:0] jj_ksa;
  logic [SW-1:0] jj_dec;
  logic [KW-1:0] klen_m1;

  // effective key length minus one: zero acts as one, large values clamp
  always_comb begin
    if (key_length_i == '0) begin
      klen_m1 = '0;
    end else if (int'(key_length_i) > rc4s_pkg::KEY_MAX) begin
      klen_m1 = KW'(rc4s_pkg::KEY_MAX - 1);
    end else begin
      klen_m1 = KW'(key_length_i - 1'b1);
    end
  end

  assign jj_ksa = j_q + rdata_q + key_q;
  assign jj_dec = j_q + rdata_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = n_q;
    mem_wdata = n_q;
    unique case (cmd_i.op)
      rc4s_pkg::OP_FILL: begin
        mem_we = 1'b1;
      end
      rc4s_pkg::OP_K_RD_J: begin
        mem_addr = jj_ksa;
      end
      rc4s_pkg::OP_K_WR_I: begin
        mem_we    = 1'b1;
        mem_wdata = same_q ? '0 : rdata_q;
      end
      rc4s_pkg::OP_K_WR_J, rc4s_pkg::OP_D_WR_J: begin
        mem_we    = 1'b1;
        mem_addr  = j_q;
        mem_wdata = x_q;
      end
      rc4s_pkg::OP_D_RD_I: begin
        mem_addr = i_q;
      end
      rc4s_pkg::OP_D_RD_J: begin
        mem_addr = jj_dec;
      end
      rc4s_pkg::OP_D_WR_I: begin
        mem_we    = 1'b1;
        mem_addr  = i_q;
        mem_wdata = same_q ? '0 : rdata_q;
      end
      rc4s_pkg::OP_D_RD_K: begin
        mem_addr = sum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= perm_mem[mem_addr];
  end

  always_comb begin
    n_d    = n_q;
    kctr_d = kctr_q;
    i_d    = i_q;
    j_d    = j_q;
    prev_d = prev_q;
    unique case (cmd_i.op)
      rc4s_pkg::OP_FILL: begin
        n_d    = n_q + 1'b1;
        kctr_d = '0;
        j_d    = '0;
      end
      rc4s_pkg::OP_K_RD_J: begin
        j_d = jj_ksa;
      end
      rc4s_pkg::OP_K_WR_I: begin
        n_d    = n_q + 1'b1;
        kctr_d = (kctr_q == klen_m1) ? '0 : kctr_q + 1'b1;
      end
      rc4s_pkg::OP_K_END: begin
        i_d    = '0;
        j_d    = '0;
        prev_d = '0;
      end
      rc4s_pkg::OP_D_RD_J: begin
        j_d = jj_dec;
      end
      rc4s_pkg::OP_D_RES: begin
        i_d    = i_q + 1'b1;
        prev_d = sym_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      kctr_q <= '0;
      i_q    <= '0;
      j_q    <= '0;
      prev_q <= '0;
    end else begin
      n_q    <= n_d;
      kctr_q <= kctr_d;
      i_q    <= i_d;
      j_q    <= j_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      rc4s_pkg::OP_ACCEPT: begin
        sym_q <= in_data_i.symbol;
        if (in_data_i.func == rc4s_pkg::FUNC_LOAD_KEY &&
            int'(in_data_i.key_index) < rc4s_pkg::KEY_MAX) begin
          key_store[in_data_i.key_index[KW-1:0]] <= in_data_i.symbol;
        end
      end
      rc4s_pkg::OP_K_RD_I: begin
        key_q <= key_store[kctr_q];
      end
      rc4s_pkg::OP_K_RD_J: begin
        x_q    <= rdata_q;
        same_q <= (jj_ksa == n_q);
      end
      rc4s_pkg::OP_D_RD_J: begin
        x_q    <= rdata_q;
        same_q <= (jj_dec == i_q);
      end
      rc4s_pkg::OP_D_WR_I: begin
        // after an i==j swap both entries read zero, so the keystream index is 0
        sum_q <= same_q ? '0 : x_q + rdata_q;
      end
      rc4s_pkg::OP_D_RES: begin
        res_q <= (sym_q - prev_q) ^ rdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.plain_symbol <= cmd_i.out_data ? res_q : '0;
      out_q.data_valid   <= cmd_i.out_data;
    end
  end

  assign status_o.n_last   = &n_q;
  assign status_o.same_idx = same_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

### hw/rtl/rc4s_ctrl.sv
// rc4s_ctrl: sequencer for key load, table fill, key schedule and decrypt steps,
// plus the output valid flag. Depends on rc4s_pkg; commands rc4s_dpath.
`timescale 1ns / 1ps
`default_nettype none

module rc4s_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [rc4s_pkg::FUNC_W-1:0] func_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  input  rc4s_pkg::dp_status_t       status_i,
  output rc4s_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RD_I,
    ST_K_RD_J,
    ST_K_WR_I,
    ST_K_WR_J,
    ST_K_END,
    ST_D_RD_I,
    ST_D_RD_J,
    ST_D_WR_I,
    ST_D_WR_J,
    ST_D_RD_K,
    ST_D_RES,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   last_q;
  logic   data_q;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op       = rc4s_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    cmd_o.out_data = data_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.op = accept ? rc4s_pkg::OP_ACCEPT : rc4s_pkg::OP_NONE;
      ST_FILL:   cmd_o.op = rc4s_pkg::OP_FILL;
      ST_K_RD_I: cmd_o.op = rc4s_pkg::OP_K_RD_I;
      ST_K_RD_J: cmd_o.op = rc4s_pkg::OP_K_RD_J;
      ST_K_WR_I: cmd_o.op = rc4s_pkg::OP_K_WR_I;
      ST_K_WR_J: cmd_o.op = rc4s_pkg::OP_K_WR_J;
      ST_K_END:  cmd_o.op = rc4s_pkg::OP_K_END;
      ST_D_RD_I: cmd_o.op = rc4s_pkg::OP_D_RD_I;
      ST_D_RD_J: cmd_o.op = rc4s_pkg::OP_D_RD_J;
      ST_D_WR_I: cmd_o.op = rc4s_pkg::OP_D_WR_I;
      ST_D_WR_J: cmd_o.op = rc4s_pkg::OP_D_WR_J;
      ST_D_RD_K: cmd_o.op = rc4s_pkg::OP_D_RD_K;
      ST_D_RES:  cmd_o.op = rc4s_pkg::OP_D_RES;
      ST_SEND:   cmd_o.out_load = slot_free;
      default:   cmd_o.op = rc4s_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      data_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            data_q <= (func_i == rc4s_pkg::FUNC_DECRYPT);
            unique case (func_i)
              rc4s_pkg::FUNC_SCHEDULE: state_q <= ST_FILL;
              rc4s_pkg::FUNC_DECRYPT:  state_q <= ST_D_RD_I;
              default:                 state_q <= ST_SEND;
            endcase
          end
        end
        ST_FILL: begin
          if (status_i.n_last) begin
            state_q <= ST_K_RD_I;
          end
        end
        ST_K_RD_I: state_q <= ST_K_RD_J;
        ST_K_RD_J: state_q <= ST_K_WR_I;
        ST_K_WR_I: begin
          // pointer advances in this cycle, so remember whether this was the last entry
          last_q <= status_i.n_last;
          if (!status_i.same_idx) begin
            state_q <= ST_K_WR_J;
          end else if (status_i.n_last) begin
            state_q <= ST_K_END;
          end else begin
            state_q <= ST_K_RD_I;
          end
        end
        ST_K_WR_J: state_q <= last_q ? ST_K_END : ST_K_RD_I;
        ST_K_END:  state_q <= ST_SEND;
        ST_D_RD_I: state_q <= ST_D_RD_J;
        ST_D_RD_J: state_q <= ST_D_WR_I;
        ST_D_WR_I: state_q <= status_i.same_idx ? ST_D_RD_K : ST_D_WR_J;
        ST_D_WR_J: state_q <= ST_D_RD_K;
        ST_D_RD_K: state_q <= ST_D_RES;
        ST_D_RES:  state_q <= ST_SEND;
        ST_SEND: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rc4_style_9bit_stream_decrypt.sv
// rc4_style_9bit_stream_decrypt: top level with the config register and the
// controller/datapath pair. Depends on rc4s_pkg, rc4s_ctrl, rc4s_dpath.
//
//   channel   | signals                                  | direction
//   ----------+------------------------------------------+----------
//   input     | in_valid_i, in_ready_o, in_data_i        | in
//   output    | out_valid_o, out_ready_i, out_data_o     | out
//   config    | psel, penable, pwrite, paddr, pwdata ... | in/out
//
// one transaction at a time through a single-port 512x9 table with registered read.
// key load and unused codes go straight to the output step; decrypt: 4-5 table accesses.
// schedule: fills all 512 entries, then passes over each entry once.
// table and key store hold no reset value; a schedule must precede decrypts.
// the result waits in the output register; a new transaction is taken meanwhile,
// and the block stalls only when handing over its next result to a full register.
`timescale 1ns / 1ps
`default_nettype none

module rc4_style_9bit_stream_decrypt (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  rc4s_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output rc4s_pkg::out_item_t                out_data_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [rc4s_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire [rc4s_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rc4s_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [rc4s_pkg::KLEN_W-1:0] key_length_q;
  rc4s_pkg::dp_cmd_t           cmd;
  rc4s_pkg::dp_status_t        status;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[rc4s_pkg::APB_ADDR_W-1] == rc4s_pkg::REG_KEY_LENGTH);
  assign prdata  = reg_sel ? rc4s_pkg::APB_DATA_W'(key_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= rc4s_pkg::KEY_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      key_length_q <= pwdata[rc4s_pkg::KLEN_W-1:0];
    end
  end

  rc4s_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rc4s_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_data_i    (in_data_i),
    .key_length_i (key_length_q),
    .status_o     (status),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
